// ===== sv/sbrp_pkg.sv =====
// ---------------------------------------------------------------------------
// sbrp_pkg
// shared types and constants for the stun binding response parser
// ---------------------------------------------------------------------------
package sbrp_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LEN_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] HDR_BYTES = COUNT_W'(20);

    localparam logic [31:0] COOKIE      = 32'h2112_A442;
    localparam logic [15:0] RESP_TYPE   = 16'h0101;
    localparam logic [15:0] ATTR_XOR    = 16'h0020;
    localparam logic [15:0] ATTR_MAPPED = 16'h0001;
    localparam logic [7:0]  FAMILY_IPV4 = 8'h01;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
    localparam logic [2:0] ST_BAD_COOKIE = 3'd3;
    localparam logic [2:0] ST_ID_MISMATCH = 3'd4;
    localparam logic [2:0] ST_OVERRUN    = 3'd5;
    localparam logic [2:0] ST_NO_ADDR    = 3'd6;

    localparam logic REG_TXN_HIGH = 1'b0;
    localparam logic REG_TXN_LOW  = 1'b1;

    typedef struct packed {
        logic       fire;
        logic       last;
        logic [7:0] data;
    } step_t;

    typedef struct packed {
        logic               attr_fire;
        logic [COUNT_W-1:0] attr_pos;
        logic [LEN_W-1:0]   msg_len;
        logic [COUNT_W-1:0] count_next;
        logic [2:0]         error_next;
    } hdr_info_t;

    typedef struct packed {
        logic        seen;
        logic [31:0] ip;
        logic [15:0] port;
    } attr_result_t;

endpackage

// ===== sv/stun_binding_response_parser.sv =====
// ---------------------------------------------------------------------------
// stun_binding_response_parser
// parses a stun binding response byte stream and reports the mapped endpoint
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  byte      byte_valid / byte_stall   rx_byte, end_of_datagram
//  result    result_valid / result_stall  found, status, public_ip, public_port
//  cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one word per cycle sustained; input register then parse logic into result register
//  the result word is registered from the input register when the final word advances
//  reset clears all parse state and both id registers
//  a stalled result only holds back the input once a second final word reaches the parser
module stun_binding_response_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_datagram,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [2:0]  status,
    output logic [31:0] public_ip,
    output logic [15:0] public_port,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import sbrp_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_last_reg;
    logic         advance;
    logic         accept;
    logic         out_free;
    logic [31:0]  txn_high_reg;
    logic [63:0]  txn_low_reg;
    step_t        step;
    hdr_info_t    info;
    attr_result_t ares;
    logic [2:0]   status_next;
    logic         out_valid_reg;
    logic         found_reg;
    logic [2:0]   status_reg;
    logic [31:0]  ip_reg;
    logic [15:0]  port_reg;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && (!in_last_reg || out_free);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;
    assign cfg_ready  = 1'b1;

    assign step.fire = advance;
    assign step.last = in_last_reg;
    assign step.data = in_data_reg;

    sbrp_hdr u_hdr (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .txn_id_high (txn_high_reg),
        .txn_id_low  (txn_low_reg),
        .info        (info)
    );

    sbrp_attr u_attr (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .info   (info),
        .result (ares)
    );

    always_comb
    begin
        if (info.count_next < HDR_BYTES)
            status_next = ST_SHORT;
        else if (info.error_next != ST_OK)
            status_next = info.error_next;
        else if ((HDR_BYTES + {1'b0, info.msg_len}) > info.count_next)
            status_next = ST_OVERRUN;
        else if (ares.seen)
            status_next = ST_OK;
        else
            status_next = ST_NO_ADDR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txn_high_reg <= '0;
            txn_low_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TXN_HIGH: txn_high_reg <= cfg_data[31:0];
                REG_TXN_LOW:  txn_low_reg  <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= rx_byte;
            in_last_reg <= end_of_datagram;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            found_reg  <= (status_next == ST_OK);
            status_reg <= status_next;
            ip_reg     <= (status_next == ST_OK) ? ares.ip : 32'd0;
            port_reg   <= (status_next == ST_OK) ? ares.port : 16'd0;
        end
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign public_ip    = ip_reg;
    assign public_port  = port_reg;

endmodule

// ===== sv/sbrp_hdr.sv =====
// ---------------------------------------------------------------------------
// sbrp_hdr
// byte counter and 20-byte header checks (type, cookie, transaction id)
// ---------------------------------------------------------------------------
module sbrp_hdr (
    input  logic               clk,
    input  logic               rst_n,
    input  sbrp_pkg::step_t    step,
    input  logic [31:0]        txn_id_high,
    input  logic [63:0]        txn_id_low,
    output sbrp_pkg::hdr_info_t info
);
    import sbrp_pkg::*;

    localparam logic [COUNT_W-1:0] POS_TYPE   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_LEN    = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_COOKIE = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] POS_ID0    = COUNT_W'(11);
    localparam logic [COUNT_W-1:0] POS_ID1    = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] POS_ID2    = COUNT_W'(19);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        shift_reg, shift_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [2:0]         error_reg, error_next;
    logic [COUNT_W-1:0] attr_pos;
    logic               attr_fire;
    logic               counting;

    always_comb
    begin
        count_next = count_reg;
        shift_next = shift_reg;
        len_next   = len_reg;
        error_next = error_reg;
        attr_fire  = 1'b0;
        attr_pos   = count_reg - HDR_BYTES;
        counting   = step.fire && (count_reg != COUNT_MAX);
        if (counting)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (count_reg < HDR_BYTES)
            begin
                shift_next = {shift_reg[23:0], step.data};
                if (count_reg == POS_TYPE && shift_next[15:0] != RESP_TYPE
                        && error_next == ST_OK)
                    error_next = ST_WRONG_TYPE;
                if (count_reg == POS_LEN)
                    len_next = shift_next[15:0];
                if (count_reg == POS_COOKIE && shift_next != COOKIE && error_next == ST_OK)
                    error_next = ST_BAD_COOKIE;
                if (count_reg == POS_ID0 && shift_next != txn_id_high && error_next == ST_OK)
                    error_next = ST_ID_MISMATCH;
                if (count_reg == POS_ID1 && shift_next != txn_id_low[63:32]
                        && error_next == ST_OK)
                    error_next = ST_ID_MISMATCH;
                if (count_reg == POS_ID2 && shift_next != txn_id_low[31:0]
                        && error_next == ST_OK)
                    error_next = ST_ID_MISMATCH;
            end
            else if (attr_pos < {1'b0, len_reg})
                attr_fire = 1'b1;
        end
    end

    assign info.attr_fire  = attr_fire;
    assign info.attr_pos   = attr_pos;
    assign info.msg_len    = len_reg;
    assign info.count_next = count_next;
    assign info.error_next = error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            shift_reg <= '0;
            len_reg   <= '0;
            error_reg <= ST_OK;
        end
        else if (step.fire && step.last)
        begin
            count_reg <= '0;
            shift_reg <= '0;
            len_reg   <= '0;
            error_reg <= ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            shift_reg <= shift_next;
            len_reg   <= len_next;
            error_reg <= error_next;
        end
    end

endmodule

// ===== sv/sbrp_attr.sv =====
// ---------------------------------------------------------------------------
// sbrp_attr
// attribute walker: tracks padded attributes and keeps the mapped endpoint
// ---------------------------------------------------------------------------
module sbrp_attr (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbrp_pkg::step_t        step,
    input  sbrp_pkg::hdr_info_t    info,
    output sbrp_pkg::attr_result_t result
);
    import sbrp_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_VAL  = 2'd1,
        PH_STOP = 2'd2
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [15:0]   type_reg, type_next;
    logic [15:0]   len_reg, len_next;
    logic [15:0]   offset_reg, offset_next;
    logic [55:0]   value_reg, value_next;
    logic          xor_seen_reg, xor_seen_next;
    logic          addr_seen_reg, addr_seen_next;
    logic [31:0]   ip_reg, ip_next;
    logic [15:0]   port_reg, port_next;
    logic [16:0]   offset_inc;
    logic [16:0]   padded;
    logic [17:0]   attr_end;

    always_comb
    begin
        phase_next     = phase_reg;
        type_next      = type_reg;
        len_next       = len_reg;
        offset_next    = offset_reg;
        value_next     = value_reg;
        xor_seen_next  = xor_seen_reg;
        addr_seen_next = addr_seen_reg;
        ip_next        = ip_reg;
        port_next      = port_reg;
        offset_inc     = {1'b0, offset_reg} + 17'd1;
        padded         = ({1'b0, len_reg} + 17'd3) & ~17'd3;
        attr_end       = 18'd0;
        if (info.attr_fire)
        begin
            case (phase_reg)
                PH_HDR:
                begin
                    if (offset_reg < 16'd2)
                        type_next = {type_reg[7:0], step.data};
                    else
                        len_next = {len_reg[7:0], step.data};
                    offset_next = offset_inc[15:0];
                    if (offset_inc == 17'd4)
                    begin
                        offset_next = '0;
                        value_next  = '0;
                        attr_end    = {1'b0, info.attr_pos} + 18'd1 + {2'b0, len_next};
                        if (attr_end > {2'b0, info.msg_len})
                            phase_next = PH_STOP;
                        else if (len_next != 16'd0)
                            phase_next = PH_VAL;
                    end
                end
                PH_VAL:
                begin
                    if (offset_reg >= 16'd1 && offset_reg <= 16'd7 && offset_reg < len_reg)
                        value_next = {value_reg[47:0], step.data};
                    if (offset_reg == 16'd7 && value_next[55:48] == FAMILY_IPV4
                            && len_reg >= 16'd8)
                    begin
                        if (type_reg == ATTR_XOR)
                        begin
                            port_next     = value_next[47:32] ^ COOKIE[31:16];
                            ip_next       = value_next[31:0] ^ COOKIE;
                            xor_seen_next = 1'b1;
                        end
                        else if (type_reg == ATTR_MAPPED && !xor_seen_reg && !addr_seen_reg)
                        begin
                            port_next      = value_next[47:32];
                            ip_next        = value_next[31:0];
                            addr_seen_next = 1'b1;
                        end
                    end
                    offset_next = offset_inc[15:0];
                    if (offset_inc >= padded)
                    begin
                        offset_next = '0;
                        phase_next  = PH_HDR;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.seen = xor_seen_next | addr_seen_next;
    assign result.ip   = ip_next;
    assign result.port = port_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HDR;
            type_reg      <= '0;
            len_reg       <= '0;
            offset_reg    <= '0;
            value_reg     <= '0;
            xor_seen_reg  <= 1'b0;
            addr_seen_reg <= 1'b0;
            ip_reg        <= '0;
            port_reg      <= '0;
        end
        else if (step.fire && step.last)
        begin
            phase_reg     <= PH_HDR;
            type_reg      <= '0;
            len_reg       <= '0;
            offset_reg    <= '0;
            value_reg     <= '0;
            xor_seen_reg  <= 1'b0;
            addr_seen_reg <= 1'b0;
            ip_reg        <= '0;
            port_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            len_reg       <= len_next;
            offset_reg    <= offset_next;
            value_reg     <= value_next;
            xor_seen_reg  <= xor_seen_next;
            addr_seen_reg <= addr_seen_next;
            ip_reg        <= ip_next;
            port_reg      <= port_next;
        end
    end

endmodule

// ===== dv/stun_binding_response_parser_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stun_binding_response_parser_tb
// Self-checking bench for the STUN binding response parser. Datagrams are
// sent one byte per word with random gaps, and results are taken under random
// stall. The directed table or a behavioural parser in the bench predicts each
// result. The run starts with a table of directed datagrams and then sends
// random datagrams, most of them well formed and some corrupt. The transaction
// id registers are written between phases, including the all-zero and all-one values.
// ---------------------------------------------------------------------------
module stun_binding_response_parser_tb;

    import sbrp_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_BYTES   = 750;
    localparam logic [31:0] DIR_IP         = 32'hC0A8_0164;
    localparam logic [15:0] DIR_PORT       = 16'hD431;
    localparam logic [31:0] MAP_IP         = 32'h0A00_0002;
    localparam logic [15:0] MAP_PORT       = 16'h1F90;

    localparam logic [1:0] PH_ATTR_HDR = 2'd0;
    localparam logic [1:0] PH_VALUE    = 2'd1;
    localparam logic [1:0] PH_STOPPED  = 2'd2;

    typedef enum logic [4:0] {
        DG_ONE_BYTE,
        DG_HDR_19,
        DG_WRONG_TYPE,
        DG_BAD_COOKIE,
        DG_ID_HIGH,
        DG_ID_LOW,
        DG_OVERRUN,
        DG_NO_ADDR,
        DG_XOR,
        DG_MAPPED,
        DG_MAPPED_XOR,
        DG_XOR_MAPPED,
        DG_TRUNC,
        DG_TRAIL,
        DG_IPV6,
        DG_SHORT_ATTR,
        DG_ALL_ONES,
        DG_ALL_ZERO
    } dg_kind_e;

    typedef struct packed {
        dg_kind_e    kind;
        logic        typed;
        logic [2:0]  status;
        logic [31:0] ip;
        logic [15:0] port;
    } dir_row_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  status;
        logic [31:0] ip;
        logic [15:0] port;
    } endpoint_t;

    typedef struct packed {
        logic [16:0] count;
        logic [31:0] shreg;
        logic [15:0] msg_len;
        logic [2:0]  hdr_err;
        logic [1:0]  phase;
        logic [15:0] a_type;
        logic [15:0] a_len;
        logic [15:0] a_off;
        logic [55:0] val;
        logic        xor_hit;
        logic        map_hit;
        logic [31:0] ip;
        logic [15:0] port;
    } parse_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        end_of_datagram = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        found;
    logic [2:0]  status;
    logic [31:0] public_ip;
    logic [15:0] public_port;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_TXN_HIGH;
    logic [63:0] cfg_data = 64'h0;

    parse_t      ps = '0;
    logic [31:0] id_hi = 32'h0;
    logic [63:0] id_lo = 64'h0;
    endpoint_t   endpoint_q [$];
    logic [7:0]  dgram [$];
    bit          calm = 1'b0;
    int          errors = 0;
    int          quiet_cycles = 0;

    dir_row_t dir_rows [18] = '{
        '{DG_ONE_BYTE,   1'b1, ST_SHORT,       32'h0,  16'h0},
        '{DG_HDR_19,     1'b1, ST_SHORT,       32'h0,  16'h0},
        '{DG_WRONG_TYPE, 1'b1, ST_WRONG_TYPE,  32'h0,  16'h0},
        '{DG_BAD_COOKIE, 1'b1, ST_BAD_COOKIE,  32'h0,  16'h0},
        '{DG_ID_HIGH,    1'b1, ST_ID_MISMATCH, 32'h0,  16'h0},
        '{DG_ID_LOW,     1'b1, ST_ID_MISMATCH, 32'h0,  16'h0},
        '{DG_OVERRUN,    1'b1, ST_OVERRUN,     32'h0,  16'h0},
        '{DG_NO_ADDR,    1'b1, ST_NO_ADDR,     32'h0,  16'h0},
        '{DG_XOR,        1'b1, ST_OK,          DIR_IP, DIR_PORT},
        '{DG_MAPPED,     1'b1, ST_OK,          MAP_IP, MAP_PORT},
        '{DG_MAPPED_XOR, 1'b1, ST_OK,          DIR_IP, DIR_PORT},
        '{DG_XOR_MAPPED, 1'b1, ST_OK,          DIR_IP, DIR_PORT},
        '{DG_TRUNC,      1'b0, ST_OK,          32'h0,  16'h0},
        '{DG_TRAIL,      1'b0, ST_OK,          32'h0,  16'h0},
        '{DG_IPV6,       1'b0, ST_OK,          32'h0,  16'h0},
        '{DG_SHORT_ATTR, 1'b0, ST_OK,          32'h0,  16'h0},
        '{DG_ALL_ONES,   1'b1, ST_WRONG_TYPE,  32'h0,  16'h0},
        '{DG_ALL_ZERO,   1'b1, ST_WRONG_TYPE,  32'h0,  16'h0}
    };

    stun_binding_response_parser u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .rx_byte         (rx_byte),
        .end_of_datagram (end_of_datagram),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .found           (found),
        .status          (status),
        .public_ip       (public_ip),
        .public_port     (public_port),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit parse_byte(input logic [7:0] b, input bit last,
                                      output endpoint_t res);
        int unsigned pos;
        int unsigned p;
        int unsigned padded;
        logic [2:0]  st;
        res = '0;
        if (ps.count < COUNT_MAX)
        begin
            pos = ps.count;
            ps.count = ps.count + 1'b1;
            if (pos < HDR_BYTES)
            begin
                ps.shreg = {ps.shreg[23:0], b};
                case (pos)
                    1:
                        if (ps.hdr_err == ST_OK && ps.shreg[15:0] != RESP_TYPE)
                            ps.hdr_err = ST_WRONG_TYPE;
                    3:
                        ps.msg_len = ps.shreg[15:0];
                    7:
                        if (ps.hdr_err == ST_OK && ps.shreg != COOKIE)
                            ps.hdr_err = ST_BAD_COOKIE;
                    11:
                        if (ps.hdr_err == ST_OK && ps.shreg != id_hi)
                            ps.hdr_err = ST_ID_MISMATCH;
                    15:
                        if (ps.hdr_err == ST_OK && ps.shreg != id_lo[63:32])
                            ps.hdr_err = ST_ID_MISMATCH;
                    19:
                        if (ps.hdr_err == ST_OK && ps.shreg != id_lo[31:0])
                            ps.hdr_err = ST_ID_MISMATCH;
                    default: ;
                endcase
            end
            else if (pos - HDR_BYTES < ps.msg_len)
            begin
                p = pos - HDR_BYTES;
                if (ps.phase == PH_ATTR_HDR)
                begin
                    if (ps.a_off < 2)
                        ps.a_type = {ps.a_type[7:0], b};
                    else
                        ps.a_len = {ps.a_len[7:0], b};
                    ps.a_off = ps.a_off + 1'b1;
                    if (ps.a_off == 4)
                    begin
                        ps.a_off = '0;
                        ps.val = '0;
                        if (p + 1 + ps.a_len > ps.msg_len)
                            ps.phase = PH_STOPPED;
                        else if (ps.a_len != 0)
                            ps.phase = PH_VALUE;
                    end
                end
                else if (ps.phase == PH_VALUE)
                begin
                    padded = (ps.a_len + 32'd3) & ~32'd3;
                    if (ps.a_off >= 1 && ps.a_off <= 7 && ps.a_off < ps.a_len)
                        ps.val = {ps.val[47:0], b};
                    if (ps.a_off == 7 && ps.val[55:48] == FAMILY_IPV4 && ps.a_len >= 8)
                    begin
                        // xor-mapped always wins, plain mapped only fills an empty slot
                        if (ps.a_type == ATTR_XOR)
                        begin
                            ps.port = ps.val[47:32] ^ COOKIE[31:16];
                            ps.ip = ps.val[31:0] ^ COOKIE;
                            ps.xor_hit = 1'b1;
                        end
                        else if (ps.a_type == ATTR_MAPPED && !ps.xor_hit && !ps.map_hit)
                        begin
                            ps.port = ps.val[47:32];
                            ps.ip = ps.val[31:0];
                            ps.map_hit = 1'b1;
                        end
                    end
                    ps.a_off = ps.a_off + 1'b1;
                    if (ps.a_off >= padded)
                    begin
                        ps.a_off = '0;
                        ps.phase = PH_ATTR_HDR;
                    end
                end
            end
        end
        if (!last)
            return 1'b0;
        if (ps.count < HDR_BYTES)
            st = ST_SHORT;
        else if (ps.hdr_err != ST_OK)
            st = ps.hdr_err;
        else if (32'(HDR_BYTES) + ps.msg_len > 32'(ps.count))
            st = ST_OVERRUN;
        else if (ps.xor_hit || ps.map_hit)
            st = ST_OK;
        else
            st = ST_NO_ADDR;
        res.found = (st == ST_OK);
        res.status = st;
        res.ip = (st == ST_OK) ? ps.ip : 32'h0;
        res.port = (st == ST_OK) ? ps.port : 16'h0;
        ps = '0;
        return 1'b1;
    endfunction

    task automatic put_bytes(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            dgram.push_back(v[8*i +: 8]);
    endtask

    task automatic put_hdr(input logic [15:0] mtype, input logic [15:0] mlen,
                           input logic [31:0] ck, input logic [31:0] hi,
                           input logic [63:0] lo);
        put_bytes(64'(mtype), 2);
        put_bytes(64'(mlen), 2);
        put_bytes(64'(ck), 4);
        put_bytes(64'(hi), 4);
        put_bytes(lo, 8);
    endtask

    task automatic put_attr(input logic [15:0] atype, input logic [15:0] alen,
                            input logic [7:0] fam, input logic [15:0] port,
                            input logic [31:0] ip);
        logic [63:0] body;
        int          padded;
        put_bytes(64'(atype), 2);
        put_bytes(64'(alen), 2);
        body = {8'($urandom), fam, port, ip};
        padded = (int'(alen) + 3) & ~3;
        for (int i = 0; i < padded; i++)
            dgram.push_back(i < 8 ? body[63 - 8*i -: 8] : 8'($urandom));
    endtask

    task automatic put_xor_dir();
        put_attr(ATTR_XOR, 16'd8, FAMILY_IPV4, DIR_PORT ^ COOKIE[31:16], DIR_IP ^ COOKIE);
    endtask

    task automatic put_mapped_alt();
        put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, MAP_PORT, MAP_IP);
    endtask

    task automatic build_directed(input dg_kind_e kind);
        dgram.delete();
        case (kind)
            DG_ONE_BYTE:
                dgram.push_back(8'h01);
            DG_HDR_19:
            begin
                put_hdr(RESP_TYPE, 16'd0, COOKIE, id_hi, id_lo);
                void'(dgram.pop_back());
            end
            // type error must win over the cookie error behind it
            DG_WRONG_TYPE:
                put_hdr(16'h0111, 16'd0, COOKIE ^ 32'h1, id_hi, id_lo);
            DG_BAD_COOKIE:
                put_hdr(RESP_TYPE, 16'd0, ~COOKIE, ~id_hi, id_lo);
            DG_ID_HIGH:
                put_hdr(RESP_TYPE, 16'd0, COOKIE, id_hi ^ 32'h8000_0000, id_lo);
            DG_ID_LOW:
                put_hdr(RESP_TYPE, 16'd0, COOKIE, id_hi, id_lo ^ 64'h1);
            DG_OVERRUN:
                put_hdr(RESP_TYPE, 16'd12, COOKIE, id_hi, id_lo);
            DG_NO_ADDR:
                put_hdr(RESP_TYPE, 16'd0, COOKIE, id_hi, id_lo);
            DG_XOR:
            begin
                put_hdr(RESP_TYPE, 16'd12, COOKIE, id_hi, id_lo);
                put_xor_dir();
            end
            DG_MAPPED:
            begin
                put_hdr(RESP_TYPE, 16'd12, COOKIE, id_hi, id_lo);
                put_mapped_alt();
            end
            DG_MAPPED_XOR:
            begin
                put_hdr(RESP_TYPE, 16'd24, COOKIE, id_hi, id_lo);
                put_mapped_alt();
                put_xor_dir();
            end
            DG_XOR_MAPPED:
            begin
                put_hdr(RESP_TYPE, 16'd24, COOKIE, id_hi, id_lo);
                put_xor_dir();
                put_mapped_alt();
            end
            DG_TRUNC:
            begin
                put_hdr(RESP_TYPE, 16'd12, COOKIE, id_hi, id_lo);
                put_attr(ATTR_XOR, 16'd12, FAMILY_IPV4, 16'($urandom), $urandom);
            end
            DG_TRAIL:
            begin
                put_hdr(RESP_TYPE, 16'd12, COOKIE, id_hi, id_lo);
                put_xor_dir();
                repeat (5) dgram.push_back(8'($urandom));
            end
            DG_IPV6:
            begin
                put_hdr(RESP_TYPE, 16'd24, COOKIE, id_hi, id_lo);
                put_attr(ATTR_XOR, 16'd20, 8'h02, 16'($urandom), $urandom);
            end
            DG_SHORT_ATTR:
            begin
                put_hdr(RESP_TYPE, 16'd24, COOKIE, id_hi, id_lo);
                put_attr(ATTR_XOR, 16'd4, FAMILY_IPV4, 16'($urandom), $urandom);
                put_attr(ATTR_MAPPED, 16'd12, FAMILY_IPV4, 16'($urandom), $urandom);
            end
            DG_ALL_ONES:
                repeat (24) dgram.push_back(8'hFF);
            default:
                repeat (24) dgram.push_back(8'h00);
        endcase
    endtask

    task automatic build_random();
        int          k;
        int          sel;
        int          alen;
        logic [15:0] atype;
        logic [7:0]  fam;
        logic [15:0] mlen;
        dgram.delete();
        if ($urandom_range(0, 99) < 12)
        begin
            k = $urandom_range(1, 40);
            repeat (k) dgram.push_back(8'($urandom));
            return;
        end
        put_hdr(RESP_TYPE, 16'd0, COOKIE, id_hi, id_lo);
        repeat ($urandom_range(0, 3))
        begin
            sel = $urandom_range(0, 99);
            atype = sel < 40 ? ATTR_XOR : sel < 70 ? ATTR_MAPPED : 16'($urandom);
            sel = $urandom_range(0, 99);
            alen = sel < 60 ? 8 : sel < 75 ? 12 : sel < 85 ? 20 : $urandom_range(0, 11);
            fam = $urandom_range(0, 99) < 85 ? FAMILY_IPV4 : 8'($urandom);
            put_attr(atype, 16'(alen), fam, 16'($urandom), $urandom);
        end
        k = dgram.size() - 20;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            k = k + $urandom_range(1, 8);
        else if (sel < 16 && k > 0)
            k = k - $urandom_range(1, k);
        mlen = 16'(k);
        dgram[2] = mlen[15:8];
        dgram[3] = mlen[7:0];
        sel = $urandom_range(0, 99);
        if (sel < 4)
            dgram[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
        else if (sel < 8)
            dgram[$urandom_range(4, 7)] ^= 8'($urandom_range(1, 255));
        else if (sel < 12)
            dgram[$urandom_range(8, 19)] ^= 8'($urandom_range(1, 255));
        sel = $urandom_range(0, 99);
        if (sel < 6)
        begin
            k = $urandom_range(1, dgram.size() - 1);
            while (dgram.size() > k)
                void'(dgram.pop_back());
        end
        else if (sel < 12)
            repeat ($urandom_range(1, 6)) dgram.push_back(8'($urandom));
    endtask

    task automatic send_dgram(input bit typed, input endpoint_t want);
        endpoint_t res;
        bit        last;
        for (int i = 0; i < dgram.size(); i++)
        begin
            while (!calm && $urandom_range(0, 99) < 15)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            last = (i == dgram.size() - 1);
            byte_valid <= 1'b1;
            rx_byte <= dgram[i];
            end_of_datagram <= last;
            do @(posedge clk); while (byte_stall);
            if (parse_byte(dgram[i], last, res))
                endpoint_q.push_back(typed ? want : res);
        end
    endtask

    // hold the sender until every result is back and the pipe has emptied
    task automatic drain();
        byte_valid <= 1'b0;
        while (endpoint_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ids(input logic [63:0] hi_data, input logic [63:0] lo_data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_TXN_HIGH;
        cfg_data <= hi_data;
        do @(posedge clk); while (!cfg_ready);
        id_hi = hi_data[31:0];
        cfg_index <= REG_TXN_LOW;
        cfg_data <= lo_data;
        do @(posedge clk); while (!cfg_ready);
        id_lo = lo_data;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        endpoint_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (endpoint_q.size() == 0)
            begin
                $display("%0t: result word with none expected, status %0d ip %h port %h",
                         $time, status, public_ip, public_port);
                errors++;
            end
            else
            begin
                want = endpoint_q.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d", $time, want.found, found);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    errors++;
                end
                if (public_ip !== want.ip)
                begin
                    $display("%0t: public_ip expected %h actual %h", $time, want.ip, public_ip);
                    errors++;
                end
                if (public_port !== want.port)
                begin
                    $display("%0t: public_port expected %h actual %h",
                             $time, want.port, public_port);
                    errors++;
                end
            end
        end
        result_stall <= !calm && ($urandom_range(0, 99) < 15);
    end

    always @(posedge clk)
    begin
        if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        endpoint_t want;
        int        rand_bytes;
        int        n;
        rand_bytes = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_ids({32'hDEAD_BEEF, 32'h0123_4567}, 64'h89AB_CDEF_FEDC_BA98);
        foreach (dir_rows[i])
        begin
            build_directed(dir_rows[i].kind);
            want.found = (dir_rows[i].status == ST_OK);
            want.status = dir_rows[i].status;
            want.ip = dir_rows[i].ip;
            want.port = dir_rows[i].port;
            send_dgram(dir_rows[i].typed, want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1: write_ids('1, '1);
                2: write_ids('0, '0);
                default: write_ids({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            n = 0;
            while (rand_bytes < (ph + 1) * RANDOM_BYTES / 4 || n < (ph == 1 ? 8 : 2))
            begin
                calm = (ph == 1 && n < 8);
                if ($urandom_range(0, 99) < 3)
                    drain();
                build_random();
                send_dgram(1'b0, '0);
                rand_bytes += dgram.size();
                n++;
            end
        end
        calm = 1'b0;
        byte_valid <= 1'b0;

        while (endpoint_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sbrp_pkg.sv
sv/sbrp_hdr.sv
sv/sbrp_attr.sv
sv/stun_binding_response_parser.sv
dv/stun_binding_response_parser_tb.sv
